// ===== design/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg: shared types for the rational add/multiply/reduce block
// Handshake structs between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package rar_pkg;

   // divider command
   typedef struct packed {
      logic start;   // latch operands and begin
   } div_ctrl_type;

   // divider status
   typedef struct packed {
      logic done;    // one-cycle pulse, results valid from here on
   } div_stat_type;

endpackage

// ===== design/rar_div.sv =====
// ----------------------------------------------------------------------------
// rar_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rar_div #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rar_pkg::div_ctrl_type ctrl,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [WIDTH-1:0]     divisor,
   output rar_pkg::div_stat_type stat,
   output logic [WIDTH-1:0]     quotient,
   output logic [WIDTH-1:0]     remainder
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [CW-1:0]    count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;

   logic [WIDTH:0]   shifted;
   logic [WIDTH+1:0] diff;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dsr_ff};

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (ctrl.start) begin
         count_in = CW'(WIDTH);
         busy_in  = 1'b1;
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         // trial subtract; keep it when no borrow
         if (!diff[WIDTH+1]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - CW'(1);
         if (count_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/rational_add_multiply_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_add_multiply_reduce: signed fraction add/multiply with gcd reduce
// Sequenced datapath around one multiplier and one shared iterative divider.
// ----------------------------------------------------------------------------
// The block takes one request of two signed fractions and a mode bit (0 add,
// 1 multiply) and returns one reduced fraction. A zero denominator turns its
// operand into 0/1. The raw result is reduced by a divisor g from Euclid's
// loop with truncated remainders, so g may be negative and flip both signs.
// One request is worked at a time; req_ready is high only while idle. The
// divider width is M = 2*OPERAND_WIDTH. A request first forms its products
// in the multiplier states, then every Euclid remainder and both final
// quotients go through the shared divider, which retires one quotient bit
// per cycle. The result is held in num/den and shown on the rsp_ outputs
// until rsp_ready takes it.
module rational_add_multiply_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic signed [OPERAND_WIDTH-1:0]   req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]   req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]   req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]   req_b_den,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [2*OPERAND_WIDTH:0]   rsp_res_num,
   output logic signed [2*OPERAND_WIDTH-1:0] rsp_res_den
);

   localparam int OW = OPERAND_WIDTH;
   localparam int PW = 2 * OW;       // product width
   localparam int NW = 2 * OW + 1;   // numerator / working width
   localparam int MW = 2 * OW;       // magnitude width into the divider

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_MUL_N1  = 4'd1;
   localparam logic [3:0] S_MUL_N2  = 4'd2;
   localparam logic [3:0] S_MUL_D   = 4'd3;
   localparam logic [3:0] S_GCD_GO  = 4'd4;
   localparam logic [3:0] S_GCD_WT  = 4'd5;
   localparam logic [3:0] S_QN_GO   = 4'd6;
   localparam logic [3:0] S_QN_WT   = 4'd7;
   localparam logic [3:0] S_QD_GO   = 4'd8;
   localparam logic [3:0] S_QD_WT   = 4'd9;
   localparam logic [3:0] S_DONE    = 4'd10;

   logic [3:0] state_ff, state_in;

   // latched operands
   logic                 mode_ff, mode_in;
   logic signed [OW-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;

   // working registers: num/den, then Euclid pair x/y (g ends in x)
   logic signed [NW-1:0] num_ff, num_in, den_ff, den_in;
   logic signed [NW-1:0] x_ff, x_in, y_ff, y_in;

   // shared multiplier
   logic signed [OW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic signed [NW-1:0] prod_ext;

   // shared divider
   rar_pkg::div_ctrl_type div_ctrl;
   rar_pkg::div_stat_type div_stat;
   logic [MW-1:0] div_dividend, div_divisor, div_quo, div_rem;

   logic [MW-1:0] x_mag, y_mag, num_mag, den_mag;
   logic signed [NW-1:0] rem_signed, quo_num, quo_den;

   logic req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      case (state_ff)
         S_MUL_N1: begin
            mul_a = an_ff;
            mul_b = mode_ff ? bn_ff : bd_ff;
         end
         S_MUL_N2: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         S_MUL_D: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign prod_ext = {prod[PW-1], prod};

   // magnitudes; every value here stays within 2^(M-1)
   assign x_mag   = x_ff[NW-1]   ? MW'(-x_ff)   : MW'(x_ff);
   assign y_mag   = y_ff[NW-1]   ? MW'(-y_ff)   : MW'(y_ff);
   assign num_mag = num_ff[NW-1] ? MW'(-num_ff) : MW'(num_ff);
   assign den_mag = den_ff[NW-1] ? MW'(-den_ff) : MW'(den_ff);

   // truncated remainder takes the dividend's sign
   assign rem_signed = x_ff[NW-1] ? -$signed({1'b0, div_rem}) : $signed({1'b0, div_rem});
   // truncated quotient sign is the xor of the operand signs
   assign quo_num = (num_ff[NW-1] ^ x_ff[NW-1]) ? -$signed({1'b0, div_quo})
                                               : $signed({1'b0, div_quo});
   assign quo_den = (den_ff[NW-1] ^ x_ff[NW-1]) ? -$signed({1'b0, div_quo})
                                               : $signed({1'b0, div_quo});

   always_comb begin
      div_ctrl.start = 1'b0;
      div_dividend   = x_mag;
      div_divisor    = y_mag;
      case (state_ff)
         S_GCD_GO: begin
            div_ctrl.start = 1'b1;
            div_dividend   = x_mag;
            div_divisor    = y_mag;
         end
         S_QN_GO: begin
            div_ctrl.start = 1'b1;
            div_dividend   = num_mag;
            div_divisor    = x_mag;
         end
         S_QD_GO: begin
            div_ctrl.start = 1'b1;
            div_dividend   = den_mag;
            div_divisor    = x_mag;
         end
         default: begin
            div_ctrl.start = 1'b0;
            div_dividend   = x_mag;
            div_divisor    = y_mag;
         end
      endcase
   end

   rar_div #(
      .WIDTH (MW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (div_ctrl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      an_in    = an_ff;
      ad_in    = ad_ff;
      bn_in    = bn_ff;
      bd_in    = bd_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               mode_in = req_mode;
               // zero denominator: operand becomes 0/1
               if (req_a_den == '0) begin
                  an_in = '0;
                  ad_in = OW'(1);
               end else begin
                  an_in = req_a_num;
                  ad_in = req_a_den;
               end
               if (req_b_den == '0) begin
                  bn_in = '0;
                  bd_in = OW'(1);
               end else begin
                  bn_in = req_b_num;
                  bd_in = req_b_den;
               end
               state_in = S_MUL_N1;
            end
         end
         S_MUL_N1: begin
            num_in   = prod_ext;
            state_in = mode_ff ? S_MUL_D : S_MUL_N2;
         end
         S_MUL_N2: begin
            den_in   = prod_ext;   // parked cross term
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            if (!mode_ff) begin
               num_in = num_ff + den_ff;
               x_in   = num_ff + den_ff;
            end else begin
               x_in   = num_ff;
            end
            den_in   = prod_ext;
            y_in     = prod_ext;
            state_in = S_GCD_GO;
         end
         S_GCD_GO: begin
            state_in = S_GCD_WT;
         end
         S_GCD_WT: begin
            if (div_stat.done) begin
               x_in     = y_ff;
               y_in     = rem_signed;
               state_in = (div_rem == '0) ? S_QN_GO : S_GCD_GO;
            end
         end
         S_QN_GO: begin
            state_in = S_QN_WT;
         end
         S_QN_WT: begin
            if (div_stat.done) begin
               num_in   = quo_num;
               state_in = S_QD_GO;
            end
         end
         S_QD_GO: begin
            state_in = S_QD_WT;
         end
         S_QD_WT: begin
            if (div_stat.done) begin
               den_in   = quo_den;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   // result held in num/den until taken
   assign rsp_valid   = (state_ff == S_DONE);
   assign rsp_res_num = num_ff;
   assign rsp_res_den = den_ff[PW-1:0];

endmodule
